FILE: rtl/core/mrex_pkg.sv
`timescale 1ns / 1ps
// Package for the R-type execute unit: operation codes, sequencer states
// and word-size constants. No dependencies.
package mrex_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned KIND_W      = 5;
   localparam int unsigned SHAMT_W     = 5;
   localparam int unsigned CNT_W       = 5;
   localparam logic [WORD_W-1:0] LINK_OFFSET = 32'd8;

   typedef enum logic [KIND_W-1:0] {
      K_ADD   = 5'd0,
      K_ADDU  = 5'd1,
      K_AND   = 5'd2,
      K_SUB   = 5'd3,
      K_SUBU  = 5'd4,
      K_XOR   = 5'd5,
      K_DIV   = 5'd6,
      K_DIVU  = 5'd7,
      K_JR    = 5'd8,
      K_JALR  = 5'd9,
      K_MFHI  = 5'd10,
      K_MFLO  = 5'd11,
      K_MTHI  = 5'd12,
      K_MTLO  = 5'd13,
      K_MULT  = 5'd14,
      K_MULTU = 5'd15,
      K_OR    = 5'd16,
      K_SLL   = 5'd17,
      K_SLLV  = 5'd18,
      K_SLT   = 5'd19,
      K_SLTU  = 5'd20,
      K_SRA   = 5'd21,
      K_SRAV  = 5'd22,
      K_SRL   = 5'd23,
      K_SRLV  = 5'd24
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CALC = 2'd1,
      ST_FIX  = 2'd2,
      ST_RESP = 2'd3
   } state_type;

endpackage

FILE: rtl/core/mips_rtype_execute_unit.sv
`timescale 1ns / 1ps
// ALU, shift, jump and HI/LO move beats respond the cycle after accept.
// MULT/MULTU/DIV/DIVU iterate the shared 34-bit add/subtract unit (one bit per
// cycle) once per operand bit, then pass a sign-fix state before responding.
// Throughput: one simple beat per cycle while rsp_ready stays high; a multiply or
// divide holds off new requests until it responds. Divide by zero is a simple beat.
// Reset (synchronous, active high) clears the sequencer and HI/LO to zero.
module mips_rtype_execute_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mrex_pkg::KIND_W-1:0]   req_kind,
   input  logic [mrex_pkg::WORD_W-1:0]   req_operand_a,
   input  logic [mrex_pkg::WORD_W-1:0]   req_operand_b,
   input  logic [mrex_pkg::SHAMT_W-1:0]  req_shift_amount,
   input  logic [mrex_pkg::WORD_W-1:0]   req_program_counter,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mrex_pkg::WORD_W-1:0]   rsp_result,
   output logic                          rsp_writes_result,
   output logic                          rsp_overflow,
   output logic                          rsp_jump_taken,
   output logic [mrex_pkg::WORD_W-1:0]   rsp_jump_target
);
   import mrex_pkg::*;

   state_type             state_ff, state_in;
   logic [WORD_W-1:0]     hi_ff, hi_in, lo_ff, lo_in;
   logic [WORD_W:0]       part_ff, part_in;
   logic [WORD_W-1:0]     lowr_ff, lowr_in;
   logic [WORD_W-1:0]     opnd_ff, opnd_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  is_div_ff, is_div_in;
   logic                  neg_lo_ff, neg_lo_in;
   logic                  neg_hi_ff, neg_hi_in;
   logic [WORD_W-1:0]     result_ff, result_in;
   logic                  writes_ff, writes_in;
   logic                  ovf_ff, ovf_in;
   logic                  jmp_ff, jmp_in;
   logic [WORD_W-1:0]     tgt_ff, tgt_in;

   logic                  accept;
   logic [WORD_W+1:0]     add_a, add_b, add_sum;
   logic                  add_cin;
   logic [WORD_W-1:0]     a, b, mag_a, mag_b, sum_ab, dif_ab;
   logic [SHAMT_W-1:0]    va;
   logic [2*WORD_W-1:0]   prod, prod_neg;
   logic                  go_calc;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_RESP && rsp_ready);
   assign rsp_valid = (state_ff == ST_RESP);

   assign a      = req_operand_a;
   assign b      = req_operand_b;
   assign va     = req_operand_a[SHAMT_W-1:0];
   assign mag_a  = a[WORD_W-1] ? (~a + 1'b1) : a;
   assign mag_b  = b[WORD_W-1] ? (~b + 1'b1) : b;
   assign sum_ab = a + b;
   assign dif_ab = a - b;

   // Shared iteration unit: add multiplicand for multiply, trial subtract for divide
   always_comb begin
      if (is_div_ff) begin
         add_a   = {1'b0, part_ff[WORD_W-1:0], lowr_ff[WORD_W-1]};
         add_b   = ~{2'b00, opnd_ff};
         add_cin = 1'b1;
      end else begin
         add_a   = {1'b0, part_ff};
         add_b   = lowr_ff[0] ? {2'b00, opnd_ff} : '0;
         add_cin = 1'b0;
      end
      add_sum = add_a + add_b + {{(WORD_W+1){1'b0}}, add_cin};
   end

   assign prod     = {part_ff[WORD_W-1:0], lowr_ff};
   assign prod_neg = ~prod + 1'b1;

   always_comb begin
      state_in  = state_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      part_in   = part_ff;
      lowr_in   = lowr_ff;
      opnd_in   = opnd_ff;
      count_in  = count_ff;
      is_div_in = is_div_ff;
      neg_lo_in = neg_lo_ff;
      neg_hi_in = neg_hi_ff;
      result_in = result_ff;
      writes_in = writes_ff;
      ovf_in    = ovf_ff;
      jmp_in    = jmp_ff;
      tgt_in    = tgt_ff;
      go_calc   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_CALC: begin
            if (is_div_ff) begin
               // Restore on borrow, else keep the difference; shift in the quotient bit
               part_in = add_sum[WORD_W+1] ? {part_ff[WORD_W-1:0], lowr_ff[WORD_W-1]}
                                           : add_sum[WORD_W:0];
               lowr_in = {lowr_ff[WORD_W-2:0], ~add_sum[WORD_W+1]};
            end else begin
               part_in = add_sum[WORD_W+1:1];
               lowr_in = {add_sum[0], lowr_ff[WORD_W-1:1]};
            end
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (is_div_ff) begin
               lo_in = neg_lo_ff ? (~lowr_ff + 1'b1) : lowr_ff;
               hi_in = neg_hi_ff ? (~part_ff[WORD_W-1:0] + 1'b1) : part_ff[WORD_W-1:0];
            end else begin
               hi_in = neg_lo_ff ? prod_neg[2*WORD_W-1:WORD_W] : prod[2*WORD_W-1:WORD_W];
               lo_in = neg_lo_ff ? prod_neg[WORD_W-1:0] : prod[WORD_W-1:0];
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Launch a new beat; may overlap the drain of the previous response
      if (accept) begin
         result_in = '0;
         writes_in = 1'b0;
         ovf_in    = 1'b0;
         jmp_in    = 1'b0;
         tgt_in    = '0;
         part_in   = '0;
         count_in  = '1;
         case (kind_type'(req_kind))
            K_ADD: begin
               if ((~(a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ sum_ab[WORD_W-1])) != 1'b0) begin
                  ovf_in = 1'b1;
               end else begin
                  result_in = sum_ab;
                  writes_in = 1'b1;
               end
            end
            K_ADDU: begin
               result_in = sum_ab;
               writes_in = 1'b1;
            end
            K_AND: begin
               result_in = a & b;
               writes_in = 1'b1;
            end
            K_SUB: begin
               if (((a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ dif_ab[WORD_W-1])) != 1'b0) begin
                  ovf_in = 1'b1;
               end else begin
                  result_in = dif_ab;
                  writes_in = 1'b1;
               end
            end
            K_SUBU: begin
               result_in = dif_ab;
               writes_in = 1'b1;
            end
            K_XOR: begin
               result_in = a ^ b;
               writes_in = 1'b1;
            end
            K_DIV: begin
               if (b != '0) begin
                  go_calc   = 1'b1;
                  is_div_in = 1'b1;
                  opnd_in   = mag_b;
                  lowr_in   = mag_a;
                  neg_lo_in = a[WORD_W-1] ^ b[WORD_W-1];
                  neg_hi_in = a[WORD_W-1];
               end
            end
            K_DIVU: begin
               if (b != '0) begin
                  go_calc   = 1'b1;
                  is_div_in = 1'b1;
                  opnd_in   = b;
                  lowr_in   = a;
                  neg_lo_in = 1'b0;
                  neg_hi_in = 1'b0;
               end
            end
            K_JR: begin
               jmp_in = 1'b1;
               tgt_in = a;
            end
            K_JALR: begin
               jmp_in    = 1'b1;
               tgt_in    = a;
               result_in = req_program_counter + LINK_OFFSET;
               writes_in = 1'b1;
            end
            K_MFHI: begin
               result_in = hi_ff;
               writes_in = 1'b1;
            end
            K_MFLO: begin
               result_in = lo_ff;
               writes_in = 1'b1;
            end
            K_MTHI: begin
               hi_in = a;
            end
            K_MTLO: begin
               lo_in = a;
            end
            K_MULT: begin
               go_calc   = 1'b1;
               is_div_in = 1'b0;
               opnd_in   = mag_a;
               lowr_in   = mag_b;
               neg_lo_in = a[WORD_W-1] ^ b[WORD_W-1];
               neg_hi_in = 1'b0;
            end
            K_MULTU: begin
               go_calc   = 1'b1;
               is_div_in = 1'b0;
               opnd_in   = a;
               lowr_in   = b;
               neg_lo_in = 1'b0;
               neg_hi_in = 1'b0;
            end
            K_OR: begin
               result_in = a | b;
               writes_in = 1'b1;
            end
            K_SLL: begin
               result_in = b << req_shift_amount;
               writes_in = 1'b1;
            end
            K_SLLV: begin
               result_in = b << va;
               writes_in = 1'b1;
            end
            K_SLT: begin
               result_in = {{(WORD_W-1){1'b0}}, ($signed(a) < $signed(b))};
               writes_in = 1'b1;
            end
            K_SLTU: begin
               result_in = {{(WORD_W-1){1'b0}}, (a < b)};
               writes_in = 1'b1;
            end
            K_SRA: begin
               result_in = WORD_W'($signed(b) >>> req_shift_amount);
               writes_in = 1'b1;
            end
            K_SRAV: begin
               result_in = WORD_W'($signed(b) >>> va);
               writes_in = 1'b1;
            end
            K_SRL: begin
               result_in = b >> req_shift_amount;
               writes_in = 1'b1;
            end
            K_SRLV: begin
               result_in = b >> va;
               writes_in = 1'b1;
            end
            default: begin
               result_in = '0;
            end
         endcase
         state_in = go_calc ? ST_CALC : ST_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end else begin
         state_ff <= state_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff   <= part_in;
      lowr_ff   <= lowr_in;
      opnd_ff   <= opnd_in;
      count_ff  <= count_in;
      is_div_ff <= is_div_in;
      neg_lo_ff <= neg_lo_in;
      neg_hi_ff <= neg_hi_in;
      result_ff <= result_in;
      writes_ff <= writes_in;
      ovf_ff    <= ovf_in;
      jmp_ff    <= jmp_in;
      tgt_ff    <= tgt_in;
   end

   assign rsp_result        = result_ff;
   assign rsp_writes_result = writes_ff;
   assign rsp_overflow      = ovf_ff;
   assign rsp_jump_taken    = jmp_ff;
   assign rsp_jump_target   = tgt_ff;

`ifndef NO_ASSERTIONS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC || state_ff == ST_FIX) |-> !req_ready)
      else $error("input taken while the multiply/divide unit is busy");

   a_last_iter_fix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && count_ff == '0) |=> state_ff == ST_FIX)
      else $error("sequencer did not leave the iteration after 32 steps");

   a_hilo_hold: assert property (@(posedge clock) disable iff (reset)
      (!accept && state_ff != ST_FIX) |=> ($stable(hi_ff) && $stable(lo_ff)))
      else $error("HI/LO changed without an accepted beat or a finished multiply/divide");

   a_ovf_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_writes_result))
      else $error("overflowed beat marked as writing the destination");

   a_tgt_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_jump_taken) |-> (rsp_jump_target == '0))
      else $error("jump target nonzero on a beat that does not jump");
`endif

endmodule
